FILE: hw/rtl/cmt_pkg.sv
// Shared types, status codes and helpers for the command tag table.
package cmt_pkg;

  localparam int unsigned TagW = 40;
  localparam int unsigned PidW = 8;
  localparam int unsigned IdW  = 9;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_CONFLICT  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic [IdW-1:0] ID_NONE = {IdW{1'b1}};

  // Request token handed from cell to cell.
  typedef struct packed {
    logic            vld;
    logic            put;
    logic [TagW-1:0] tag;
    logic [PidW-1:0] pid;
    logic            done;
    logic [IdW-1:0]  pid_out;
    logic [1:0]      status;
  } tok_t;

  // Tag ends at its first zero byte.
  function automatic logic [TagW-1:0] norm_tag(input logic [TagW-1:0] raw);
    logic [TagW-1:0] kept;
    logic            stop;
    kept = '0;
    stop = 1'b0;
    for (int b = 0; b < TagW / 8; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        kept[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

FILE: hw/rtl/cmt_cell.sv
// One table entry: holds a tag and its id, resolves a passing request token.
module cmt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  cmt_pkg::tok_t tok_i,
  output cmt_pkg::tok_t tok_o,
  output logic          filled_o
);
  import cmt_pkg::*;

  tok_t            tok_d, tok_q;
  logic [TagW-1:0] tag_d, tag_q;
  logic [IdW-1:0]  id_d, id_q;
  logic [IdW-1:0]  new_id;
  logic            empty;
  logic            hit;

  assign empty  = (tag_q[7:0] == 8'd0);
  assign hit    = (tag_q == tok_i.tag);
  assign new_id = {1'b0, tok_i.pid};

  always_comb begin
    tok_d = tok_i;
    tag_d = tag_q;
    id_d  = id_q;
    if (tok_i.vld && !tok_i.done) begin
      if (empty) begin
        tok_d.done = 1'b1;
        if (tok_i.put == REQ_PUT) begin
          tag_d          = tok_i.tag;
          id_d           = new_id;
          tok_d.pid_out  = new_id;
          tok_d.status   = ST_OK;
        end else begin
          tok_d.pid_out  = ID_NONE;
          tok_d.status   = ST_NOT_FOUND;
        end
      end else if (hit) begin
        tok_d.done = 1'b1;
        if (tok_i.put == REQ_PUT) begin
          if (id_q == ID_NONE || id_q == new_id) begin
            id_d          = new_id;
            tok_d.pid_out = new_id;
            tok_d.status  = ST_OK;
          end else begin
            tok_d.pid_out = id_q;
            tok_d.status  = ST_CONFLICT;
          end
        end else begin
          tok_d.pid_out = id_q;
          tok_d.status  = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      tag_q <= '0;
      id_q  <= ID_NONE;
    end else if (en_i) begin
      tok_q <= tok_d;
      tag_q <= tag_d;
      id_q  <= id_d;
    end
  end

  assign tok_o    = tok_q;
  assign filled_o = !empty;

endmodule

FILE: hw/rtl/command_tag_table.sv
// Command tag table: a chain of entry cells mapping tags to process ids.
//
// Requests arrive on the s_axis channel: tuser is the request kind (0 lookup,
// 1 register), tdata carries the five-byte tag and the process id. Each
// transaction produces exactly one result on m_axis: the id stored for the
// tag (or all ones for none) and a status code.
// A request walks the chain of TABLE_ENTRIES cells, one cell per cycle while the
// chain is not held, and then reaches the output register. The chain is a
// pipeline, so one request is taken per cycle unless the receiver stalls; a
// later request always meets the updates of earlier ones.
// Entries fill in order from cell zero and are never removed.
// Reset empties every entry and clears all requests in flight.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_axis_tready_o drops until the result is taken.
module command_tag_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // tag[39:0], pid[47:40]
  input  logic        s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // pid_out[8:0], status[10:9], zero[15:11]
);
  import cmt_pkg::*;

  tok_t                     tok_w [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] filled_w;
  logic                     en;
  logic [TagW-1:0]          in_tag;
  tok_t                     last_tok;
  logic                     out_vld_q;
  logic [IdW-1:0]           out_pid_d, out_pid_q;
  logic [1:0]               out_st_d, out_st_q;

  assign en     = !out_vld_q || m_axis_tready_i;
  assign in_tag = norm_tag(s_axis_tdata_i[TagW-1:0]);

  always_comb begin
    tok_w[0]         = '0;
    tok_w[0].vld     = s_axis_tvalid_i;
    tok_w[0].put     = s_axis_tuser_i;
    tok_w[0].tag     = in_tag;
    tok_w[0].pid     = s_axis_tdata_i[TagW +: PidW];
    if (in_tag == '0) begin
      tok_w[0].done    = 1'b1;
      tok_w[0].pid_out = ID_NONE;
      tok_w[0].status  = ST_NOT_FOUND;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    cmt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .tok_i    (tok_w[i]),
      .tok_o    (tok_w[i+1]),
      .filled_o (filled_w[i])
    );
  end

  assign last_tok = tok_w[TABLE_ENTRIES];

  always_comb begin
    out_pid_d = last_tok.pid_out;
    out_st_d  = last_tok.status;
    if (!last_tok.done) begin
      out_pid_d = ID_NONE;
      out_st_d  = (last_tok.put == REQ_PUT) ? ST_FULL : ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= last_tok.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pid_q <= out_pid_d;
      out_st_q  <= out_st_d;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_st_q, out_pid_q};

  a_none_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_st_q == ST_NOT_FOUND || out_st_q == ST_FULL))
      |-> out_pid_q == ID_NONE)
    else $error("miss result carries an id");

  a_conflict_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_st_q == ST_CONFLICT) |-> out_pid_q != ID_NONE)
    else $error("conflict reported against an unset id");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_w & (filled_w + TABLE_ENTRIES'(1))) == '0)
    else $error("table entries not filled in order");

endmodule

FILE: test/tb_command_tag_table.sv
// Testbench for command_tag_table: directed requests and a random request stream checked against a tag table predictor.
`timescale 1ns / 100ps

module tb_command_tag_table;
  import cmt_pkg::*;

  localparam int ENTRIES         = 16;
  localparam int POOL_SIZE       = 24;
  localparam int RANDOM_REQUESTS = 1400;
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 2 * ENTRIES + 4;
  localparam int IDLE_LIMIT      = 2000;

  typedef struct {
    logic            kind;
    logic [TagW-1:0] tag;
    logic [PidW-1:0] pid;
  } tag_request_t;

  typedef struct {
    logic [IdW-1:0] pid;
    logic [1:0]     status;
  } tag_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  tag_request_t request_queue[$];
  tag_reply_t   pending_replies[$];

  // predictor copy of the table
  logic [TagW-1:0] tbl_tag[ENTRIES];
  logic [IdW-1:0]  tbl_id[ENTRIES];

  logic [TagW-1:0] pool_key[POOL_SIZE];
  logic [PidW-1:0] pool_pid[POOL_SIZE];

  logic [31:0] cycle_count = '0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        in_taken = 1'b0;
  int          requests_taken = 0;
  int          replies_seen = 0;
  int          mismatches = 0;
  int          status_count[4] = '{0, 0, 0, 0};

  wire calm = (cycle_count[8:7] == 2'b01);

  command_tag_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [TagW-1:0] trim_tag(input logic [TagW-1:0] raw);
    logic [TagW-1:0] key;
    int              b;
    key = '0;
    for (b = 0; b < TagW / 8; b++) begin
      if (raw[8*b +: 8] == 8'h00) break;
      key[8*b +: 8] = raw[8*b +: 8];
    end
    return key;
  endfunction

  // Scan up to the first free slot; register claims that slot if the key is absent.
  function automatic void lookup_and_update(input tag_request_t req, output tag_reply_t r);
    logic [TagW-1:0] key;
    logic            found;
    logic            has_free;
    int              slot;
    int              i;
    key      = trim_tag(req.tag);
    r.pid    = ID_NONE;
    r.status = ST_NOT_FOUND;
    found    = 1'b0;
    has_free = 1'b0;
    slot     = 0;
    if (key[7:0] == 8'h00) return;
    for (i = 0; i < ENTRIES; i++) begin
      if (tbl_tag[i][7:0] == 8'h00) begin
        has_free = 1'b1;
        slot = i;
        break;
      end
      if (tbl_tag[i] == key) begin
        found = 1'b1;
        slot = i;
        break;
      end
    end
    if (req.kind == REQ_GET) begin
      if (found) begin
        r.pid    = tbl_id[slot];
        r.status = ST_OK;
      end
      return;
    end
    if (!found && !has_free) begin
      r.status = ST_FULL;
      return;
    end
    if (!found) tbl_tag[slot] = key;
    if (tbl_id[slot] == ID_NONE || tbl_id[slot] == {1'b0, req.pid}) begin
      tbl_id[slot] = {1'b0, req.pid};
      r.pid        = {1'b0, req.pid};
      r.status     = ST_OK;
    end else begin
      r.pid    = tbl_id[slot];
      r.status = ST_CONFLICT;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TagW-1:0] make_key(input int len);
    logic [TagW-1:0] key;
    int              b;
    key = '0;
    for (b = 0; b < len; b++) key[8*b +: 8] = 8'($urandom_range(1, 255));
    return key;
  endfunction

  // Optionally put junk above the terminating zero byte.
  function automatic logic [TagW-1:0] dress_tag(input logic [TagW-1:0] key);
    logic [TagW-1:0] raw;
    int              len;
    int              b;
    raw = key;
    len = 0;
    for (b = 0; b < TagW / 8; b++) if (key[8*b +: 8] != 8'h00) len = b + 1;
    if (len < TagW / 8 - 1 && $urandom_range(0, 1) == 1) begin
      for (b = len + 1; b < TagW / 8; b++) raw[8*b +: 8] = 8'($urandom_range(0, 255));
    end
    return raw;
  endfunction

  function automatic logic [TagW-1:0] random_tag();
    logic [TagW-1:0] t;
    t[39:32] = 8'($urandom_range(0, 255));
    t[31:0]  = $urandom;
    return t;
  endfunction

  task automatic queue_request(input logic kind, input logic [TagW-1:0] tag,
                               input logic [PidW-1:0] pid);
    tag_request_t req;
    req.kind = kind;
    req.tag  = tag;
    req.pid  = pid;
    request_queue.push_back(req);
  endtask

  // driver
  always @(negedge clk_i) begin
    tag_request_t req;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || in_taken) begin
      if (gap_left > 0 && hold_left == 0) begin
        gap_left = gap_left - 1;
        s_valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        req = request_queue.pop_front();
        s_tdata  <= {req.pid, req.tag};
        s_tuser  <= req.kind;
        s_valid  <= 1'b1;
        gap_left = calm ? 0 : pick_gap();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && replies_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = calm ? 0 : pick_gap();
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    tag_request_t req;
    tag_reply_t   want;
    logic [IdW-1:0] got_pid;
    logic [1:0]     got_status;
    in_taken <= rst_ni && s_valid && s_tready;
    if (rst_ni && m_tvalid && m_tready) begin
      got_pid    = m_tdata[8:0];
      got_status = m_tdata[10:9];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result pid_out %h status %0d", $time, got_pid, got_status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got_pid !== want.pid || got_status !== want.status || m_tdata[15:11] !== 5'd0) begin
          $display("%0t: result %0d expected pid_out %h status %0d,",
                   $time, replies_seen, want.pid, want.status);
          $display("    actual pid_out %h status %0d pad %h",
                   got_pid, got_status, m_tdata[15:11]);
          mismatches++;
        end
      end
      replies_seen++;
    end
    if (rst_ni && s_valid && s_tready) begin
      req.kind = s_tuser;
      req.tag  = s_tdata[39:0];
      req.pid  = s_tdata[47:40];
      lookup_and_update(req, want);
      pending_replies.push_back(want);
      status_count[want.status]++;
      requests_taken++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if ((s_valid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int   k;
    int   j;
    int   n;
    int   pick;
    logic dup;
    logic kind;
    logic [TagW-1:0] tag;
    logic [PidW-1:0] pid;

    for (k = 0; k < ENTRIES; k++) begin
      tbl_tag[k] = '0;
      tbl_id[k]  = ID_NONE;
    end

    pool_key[0] = 40'hFF_FF_FF_FF_FF;
    pool_pid[0] = 8'd0;
    pool_key[1] = 40'h00_00_00_00_41;
    pool_pid[1] = 8'd255;
    for (k = 2; k < POOL_SIZE; k++) begin
      do begin
        pool_key[k] = make_key($urandom_range(1, 5));
        dup = 1'b0;
        for (j = 0; j < k; j++) if (pool_key[j] == pool_key[k]) dup = 1'b1;
      end while (dup);
      pool_pid[k] = 8'($urandom_range(0, 255));
    end

    // empty keys
    queue_request(REQ_GET, 40'h0, 8'd0);
    queue_request(REQ_PUT, 40'h0, 8'd5);
    queue_request(REQ_PUT, 40'hFF_FF_FF_FF_00, 8'd7);
    // all-ones key: miss, claim, repeat, conflict, hit
    queue_request(REQ_GET, pool_key[0], 8'd0);
    queue_request(REQ_PUT, pool_key[0], pool_pid[0]);
    queue_request(REQ_PUT, pool_key[0], pool_pid[0]);
    queue_request(REQ_PUT, pool_key[0], 8'd255);
    queue_request(REQ_GET, pool_key[0], 8'd255);
    // junk after the terminator
    queue_request(REQ_PUT, 40'h00_77_00_00_41, pool_pid[1]);
    queue_request(REQ_GET, 40'h00_00_00_00_41, 8'd0);
    queue_request(REQ_GET, 40'h00_00_AB_00_41, 8'd0);
    for (k = 2; k < ENTRIES; k++) queue_request(REQ_PUT, dress_tag(pool_key[k]), pool_pid[k]);
    // table now full
    queue_request(REQ_PUT, pool_key[ENTRIES], pool_pid[ENTRIES]);
    queue_request(REQ_GET, pool_key[ENTRIES + 1], 8'd0);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      kind = 1'($urandom_range(0, 1));
      pid  = 8'($urandom_range(0, 255));
      if (pick < 75) begin
        k   = $urandom_range(0, POOL_SIZE - 1);
        tag = dress_tag(pool_key[k]);
        if ($urandom_range(0, 9) < 6) pid = pool_pid[k];
      end else if (pick < 88) begin
        tag = random_tag();
      end else if (pick < 95) begin
        tag      = random_tag();
        tag[7:0] = 8'h00;
      end else begin
        tag = dress_tag(make_key($urandom_range(1, 5)));
      end
      queue_request(kind, tag, pid);
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || s_valid) @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results for %0d requests, incl. a %0d-cycle output hold.",
             replies_seen, requests_taken, HOLD_CYCLES);
    $display("Status mix: ok %0d, not found %0d, conflict %0d, table full %0d.",
             status_count[ST_OK], status_count[ST_NOT_FOUND], status_count[ST_CONFLICT],
             status_count[ST_FULL]);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cmt_pkg.sv
hw/rtl/cmt_cell.sv
hw/rtl/command_tag_table.sv
test/tb_command_tag_table.sv
